@@ hw/rtl/lafh_pkg.sv @@
// Shared types, constants and codes for the load-aware fan controller.
package lafh_pkg;

    localparam int DEF_COUNTER_BITS = 48;
    localparam int DEF_TIME_BITS    = 32;

    localparam int TEMP_W     = 19;
    localparam int LOAD_W     = 15;
    localparam int MIN_ON_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int OUT_DATA_W = 24;
    localparam int NUM_CNT    = 8;
    localparam int SEQ_IDX_W  = 3;
    localparam int QUOT_BITS  = 15;
    localparam int QCNT_W     = 4;

    // Load is d_active * 25 * 1024 / d_total: x25 built as x16 + x8 + x1.
    localparam int MUL_GROW   = 5;
    localparam int LOW_ZEROS  = 10;

    localparam logic [LOAD_W-1:0] FULL_LOAD = 15'd25600;

    localparam logic signed [TEMP_W-1:0] RST_TEMP_ON   = 19'sd56000;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_OFF  = 19'sd46000;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_BUSY = 19'sd50000;
    localparam logic [LOAD_W-1:0]        RST_BUSY_LOAD = 15'd16640;
    localparam logic [MIN_ON_W-1:0]      RST_MIN_ON    = 16'd25;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_ON   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BUSY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_LOAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON    = 3'd4;

    // Last counter slot of the active sum within the reordered counter set
    localparam logic [SEQ_IDX_W-1:0] SEQ_LAST_ACTIVE = 3'd5;
    localparam logic [SEQ_IDX_W-1:0] SEQ_LAST_TOTAL  = 3'd7;
    localparam logic [QCNT_W-1:0]    QCNT_LAST       = 4'd14;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SUM    = 9'b000000010,
        ST_DIFF_A = 9'b000000100,
        ST_DIFF_T = 9'b000001000,
        ST_CMP    = 9'b000010000,
        ST_MUL1   = 9'b000100000,
        ST_MUL2   = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_DECIDE = 9'b100000000
    } t_state;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_on;
        logic signed [TEMP_W-1:0] temp_off;
        logic signed [TEMP_W-1:0] temp_busy;
        logic [LOAD_W-1:0]        busy_load;
        logic [MIN_ON_W-1:0]      min_on;
    } t_fan_cfg;

    typedef struct packed {
        logic fan_on;
        logic switched;
    } t_fan_res;

endpackage

@@ hw/rtl/lafh_alu.sv @@
// Shared add/subtract unit with carry out, used by every arithmetic step of the sequencer.
module lafh_alu #(
    parameter int W = 56
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_res,
    output logic         o_cout
);

    logic [W:0] sum;

    // sub: a + ~b + 1, carry out set means a >= b
    assign sum    = {1'b0, i_a} + {1'b0, i_b ^ {W{i_sub}}} + {{W{1'b0}}, i_sub};
    assign o_res  = sum[W-1:0];
    assign o_cout = sum[W];

endmodule

@@ hw/rtl/lafh_fan.sv @@
// Fan hysteresis decision and run state (drive and start time).
module lafh_fan #(
    parameter int TIME_BITS = lafh_pkg::DEF_TIME_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic signed [lafh_pkg::TEMP_W-1:0]  i_temp,
    input  logic [TIME_BITS-1:0]                i_now,
    input  logic [lafh_pkg::LOAD_W-1:0]         i_load,
    input  lafh_pkg::t_fan_cfg                  i_cfg,
    output lafh_pkg::t_fan_res                  o_res
);

    logic                 r_running;
    logic [TIME_BITS-1:0] r_on_since;
    logic [TIME_BITS-1:0] elapsed;
    logic                 hot;
    logic                 busy;
    logic                 may_stop;
    logic                 start;
    logic                 stop;

    assign hot  = $signed(i_temp) >= $signed(i_cfg.temp_on);
    assign busy = ($signed(i_temp) >= $signed(i_cfg.temp_busy)) && (i_load >= i_cfg.busy_load);

    assign elapsed  = i_now - r_on_since;
    assign may_stop = (elapsed >= TIME_BITS'(i_cfg.min_on))
                   && ($signed(i_temp) < $signed(i_cfg.temp_off))
                   && (i_load < i_cfg.busy_load);

    assign start = !r_running && (hot || busy);
    assign stop  = r_running && may_stop;

    assign o_res.fan_on   = start ? 1'b1 : (stop ? 1'b0 : r_running);
    assign o_res.switched = start || stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_on_since <= '0;
        end else if (i_en) begin
            r_running <= o_res.fan_on;
            if (start) begin
                r_on_since <= i_now;
            end
        end
    end

endmodule

@@ hw/rtl/load_aware_fan_hysteresis.sv @@
// Top level of the load-aware fan controller: sequencer, datapath and ports.
//
// Each input transaction carries eight cumulative CPU tick counters, a temperature
// in millidegrees and a seconds timestamp; exactly one result transaction follows
// it, carrying the fan drive, a switched flag and the load in 1/256 percent
// (floor(d_active * 25600 / d_total), 0 on the first sample or a zero total
// difference). All arithmetic runs through one shared add/subtract unit under a
// one-hot sequencer: eight accumulate steps for the sums, two differences, one
// compare, two steps for the x25 scaling and fifteen restoring-division steps,
// then one decision step. An item occupies the block from acceptance until its
// decision step (the division is skipped on the first sample, a zero total
// difference or full load), and the decision waits for the output register to
// drain; s_axis_tready is high only in idle. The output register lets the next
// transaction be taken while a result is still waiting. Configuration must be
// written through i_cfg_we/i_cfg_idx/i_cfg_data only while idle, which the block
// does not enforce; indexes beyond the register list are ignored.
module load_aware_fan_hysteresis #(
    parameter int COUNTER_BITS = lafh_pkg::DEF_COUNTER_BITS,
    parameter int TIME_BITS    = lafh_pkg::DEF_TIME_BITS,
    localparam int IN_FIELDS_W = 8 * COUNTER_BITS + lafh_pkg::TEMP_W + TIME_BITS,
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [lafh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lafh_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // sample stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // from bit 0: ticks_user, ticks_nice, ticks_system, ticks_idle, ticks_iowait,
    // ticks_irq, ticks_softirq, ticks_steal, temperature_milli, now_seconds, zero pad
    input  logic [IN_DATA_W-1:0]               s_axis_tdata,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // from bit 0: fan_on, fan_switched, load_q8[14:0], zero pad
    output logic [lafh_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int CB    = COUNTER_BITS;
    localparam int SUM_W = COUNTER_BITS + 3;
    localparam int ALU_W = SUM_W + lafh_pkg::MUL_GROW;
    localparam int QB    = lafh_pkg::QUOT_BITS;
    localparam int TEMP_LSB = 8 * COUNTER_BITS;
    localparam int NOW_LSB  = TEMP_LSB + lafh_pkg::TEMP_W;

    lafh_pkg::t_state r_state, n_state;

    // config registers
    lafh_pkg::t_fan_cfg r_cfg;

    // latched sample; counters reordered: six active ones first, then idle, iowait
    logic [CB-1:0]                       r_cnt [lafh_pkg::NUM_CNT];
    logic signed [lafh_pkg::TEMP_W-1:0]  r_temp;
    logic [TIME_BITS-1:0]                r_now;

    logic [lafh_pkg::SEQ_IDX_W-1:0]      r_idx;
    logic [SUM_W-1:0]                    r_acc;
    logic [SUM_W-1:0]                    r_active;
    logic [SUM_W-1:0]                    r_last_active;
    logic [SUM_W-1:0]                    r_last_total;
    logic                                r_first;
    logic [SUM_W-1:0]                    r_da;
    logic [SUM_W-1:0]                    r_dt;
    logic [ALU_W-1:0]                    r_m;
    logic [SUM_W-1:0]                    r_rem;
    logic [QB-1:0]                       r_nbits;
    logic [QB-1:0]                       r_q;
    logic [lafh_pkg::QCNT_W-1:0]         r_qcnt;
    logic [lafh_pkg::LOAD_W-1:0]         r_load;

    logic                                r_out_valid;
    logic [lafh_pkg::OUT_DATA_W-1:0]     r_out_data;

    // shared unit
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W-1:0] alu_res;
    logic             alu_cout;

    logic               in_take;
    logic               out_free;
    logic               decide;
    lafh_pkg::t_fan_res fan_res;

    assign s_axis_tready = (r_state == lafh_pkg::ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign decide        = (r_state == lafh_pkg::ST_DECIDE) && out_free;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    lafh_alu #(.W(ALU_W)) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_sub  (alu_sub),
        .o_res  (alu_res),
        .o_cout (alu_cout)
    );

    lafh_fan #(.TIME_BITS(TIME_BITS)) u_fan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (decide),
        .i_temp  (r_temp),
        .i_now   (r_now),
        .i_load  (r_load),
        .i_cfg   (r_cfg),
        .o_res   (fan_res)
    );

    // operand selection for the shared unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            lafh_pkg::ST_SUM: begin
                alu_a = ALU_W'(r_acc);
                alu_b = ALU_W'(r_cnt[r_idx]);
            end
            lafh_pkg::ST_DIFF_A: begin
                alu_a   = ALU_W'(r_active);
                alu_b   = ALU_W'(r_last_active);
                alu_sub = 1'b1;
            end
            lafh_pkg::ST_DIFF_T: begin
                alu_a   = ALU_W'(r_acc);
                alu_b   = ALU_W'(r_last_total);
                alu_sub = 1'b1;
            end
            lafh_pkg::ST_CMP: begin
                alu_a   = ALU_W'(r_da);
                alu_b   = ALU_W'(r_dt);
                alu_sub = 1'b1;
            end
            lafh_pkg::ST_MUL1: begin
                alu_a = ALU_W'({r_da, 4'b0});
                alu_b = ALU_W'({r_da, 3'b0});
            end
            lafh_pkg::ST_MUL2: begin
                alu_a = r_m;
                alu_b = ALU_W'(r_da);
            end
            lafh_pkg::ST_DIV: begin
                alu_a   = ALU_W'({r_rem, r_nbits[QB-1]});
                alu_b   = ALU_W'(r_dt);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            lafh_pkg::ST_IDLE: begin
                if (in_take) n_state = lafh_pkg::ST_SUM;
            end
            lafh_pkg::ST_SUM: begin
                if (r_idx == lafh_pkg::SEQ_LAST_TOTAL) n_state = lafh_pkg::ST_DIFF_A;
            end
            lafh_pkg::ST_DIFF_A: n_state = lafh_pkg::ST_DIFF_T;
            lafh_pkg::ST_DIFF_T: n_state = lafh_pkg::ST_CMP;
            lafh_pkg::ST_CMP: begin
                // no previous sample, zero total difference or full load skip the divide
                if (r_first || (r_dt == '0) || alu_cout) n_state = lafh_pkg::ST_DECIDE;
                else n_state = lafh_pkg::ST_MUL1;
            end
            lafh_pkg::ST_MUL1: n_state = lafh_pkg::ST_MUL2;
            lafh_pkg::ST_MUL2: n_state = lafh_pkg::ST_DIV;
            lafh_pkg::ST_DIV: begin
                if (r_qcnt == lafh_pkg::QCNT_LAST) n_state = lafh_pkg::ST_DECIDE;
            end
            lafh_pkg::ST_DECIDE: begin
                if (out_free) n_state = lafh_pkg::ST_IDLE;
            end
            default: n_state = lafh_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lafh_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_last_active <= '0;
            r_last_total  <= '0;
            r_cfg.temp_on   <= lafh_pkg::RST_TEMP_ON;
            r_cfg.temp_off  <= lafh_pkg::RST_TEMP_OFF;
            r_cfg.temp_busy <= lafh_pkg::RST_TEMP_BUSY;
            r_cfg.busy_load <= lafh_pkg::RST_BUSY_LOAD;
            r_cfg.min_on    <= lafh_pkg::RST_MIN_ON;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lafh_pkg::CFG_TEMP_ON:   r_cfg.temp_on   <= i_cfg_data;
                    lafh_pkg::CFG_TEMP_OFF:  r_cfg.temp_off  <= i_cfg_data;
                    lafh_pkg::CFG_TEMP_BUSY: r_cfg.temp_busy <= i_cfg_data;
                    lafh_pkg::CFG_BUSY_LOAD:
                        r_cfg.busy_load <= i_cfg_data[lafh_pkg::LOAD_W-1:0];
                    lafh_pkg::CFG_MIN_ON:
                        r_cfg.min_on <= i_cfg_data[lafh_pkg::MIN_ON_W-1:0];
                    default: ;
                endcase
            end

            // previous sums move on once both differences are formed
            if (r_state == lafh_pkg::ST_DIFF_T) begin
                r_last_active <= r_active;
                r_last_total  <= r_acc;
            end

            if (decide) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            lafh_pkg::ST_IDLE: begin
                r_cnt[0] <= s_axis_tdata[0*CB +: CB];
                r_cnt[1] <= s_axis_tdata[1*CB +: CB];
                r_cnt[2] <= s_axis_tdata[2*CB +: CB];
                r_cnt[3] <= s_axis_tdata[5*CB +: CB];
                r_cnt[4] <= s_axis_tdata[6*CB +: CB];
                r_cnt[5] <= s_axis_tdata[7*CB +: CB];
                r_cnt[6] <= s_axis_tdata[3*CB +: CB];
                r_cnt[7] <= s_axis_tdata[4*CB +: CB];
                r_temp   <= s_axis_tdata[TEMP_LSB +: lafh_pkg::TEMP_W];
                r_now    <= s_axis_tdata[NOW_LSB +: TIME_BITS];
                r_acc    <= '0;
                r_idx    <= '0;
            end
            lafh_pkg::ST_SUM: begin
                r_acc <= alu_res[SUM_W-1:0];
                r_idx <= r_idx + 1'b1;
                if (r_idx == lafh_pkg::SEQ_LAST_ACTIVE) r_active <= alu_res[SUM_W-1:0];
            end
            lafh_pkg::ST_DIFF_A: begin
                r_da <= alu_res[SUM_W-1:0];
            end
            lafh_pkg::ST_DIFF_T: begin
                r_dt    <= alu_res[SUM_W-1:0];
                r_first <= (r_last_total == '0);
            end
            lafh_pkg::ST_CMP: begin
                if (r_first || (r_dt == '0)) r_load <= '0;
                else if (alu_cout) r_load <= lafh_pkg::FULL_LOAD;
            end
            lafh_pkg::ST_MUL1: begin
                r_m <= alu_res;
            end
            lafh_pkg::ST_MUL2: begin
                // numerator is (da*25) << 10; quotient fits 15 bits, so the upper
                // part starts as remainder and the low 15 bits are shifted in
                r_rem   <= alu_res[ALU_W-1:lafh_pkg::MUL_GROW];
                r_nbits <= {alu_res[lafh_pkg::MUL_GROW-1:0], {lafh_pkg::LOW_ZEROS{1'b0}}};
                r_q     <= '0;
                r_qcnt  <= '0;
            end
            lafh_pkg::ST_DIV: begin
                if (alu_cout) r_rem <= alu_res[SUM_W-1:0];
                else r_rem <= {r_rem[SUM_W-2:0], r_nbits[QB-1]};
                r_nbits <= {r_nbits[QB-2:0], 1'b0};
                r_q     <= {r_q[QB-2:0], alu_cout};
                r_qcnt  <= r_qcnt + 1'b1;
                if (r_qcnt == lafh_pkg::QCNT_LAST) r_load <= {r_q[QB-2:0], alu_cout};
            end
            lafh_pkg::ST_DECIDE: begin
                if (out_free) begin
                    r_out_data <= lafh_pkg::OUT_DATA_W'({r_load, fan_res.switched,
                                                         fan_res.fan_on});
                end
            end
            default: ;
        endcase
    end

endmodule
